[src/ebed_pkg.sv]
`default_nettype none
package ebed_pkg;
	localparam int NUM_SECTIONS = 4;
	localparam int WINDOW_LENGTH = 128;
	localparam int WIN_AW = $clog2(WINDOW_LENGTH);
	localparam int SUM_W = $clog2(WINDOW_LENGTH * 4096 + 1);
	localparam int ENV_W = 14;
	localparam int ACC_W = 52;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAC,
		ST_SCALE,
		ST_WINDOW,
		ST_OUT
	} ebed_state_t;

	// Coefficient table: row per section, columns a1, a2, b0, b1, b2 (Q2.16).
	function automatic logic signed [18:0] coef(input logic [1:0] s, input logic [2:0] k);
		logic signed [18:0] r;
		r = '0;
		case (s)
			2'd0: case (k)
				3'd0: r = 19'sd3381;
				3'd1: r = 19'sd23821;
				3'd2: r = 19'sd1217;
				3'd3: r = 19'sd2433;
				default: r = 19'sd1217;
			endcase
			2'd1: case (k)
				3'd0: r = -19'sd35354;
				3'd1: r = 19'sd26060;
				3'd2: r = 19'sd65536;
				3'd3: r = -19'sd131072;
				default: r = 19'sd65536;
			endcase
			2'd2: case (k)
				3'd0: r = 19'sd31011;
				3'd1: r = 19'sd46363;
				3'd2: r = 19'sd65536;
				3'd3: r = 19'sd131072;
				default: r = 19'sd65536;
			endcase
			default: case (k)
				3'd0: r = -19'sd65674;
				3'd1: r = 19'sd48838;
				3'd2: r = 19'sd65536;
				3'd3: r = -19'sd131072;
				default: r = 19'sd65536;
			endcase
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

[src/ebed_if.sv]
`default_nettype none
interface ebed_in_if;
	logic       valid;
	logic       ready;
	logic [9:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface ebed_out_if;
	logic               valid;
	logic               ready;
	logic signed [12:0] filtered;
	logic [13:0]        envelope;
	logic               close;
	modport source (output valid, output filtered, output envelope, output close, input ready);
	modport sink (input valid, input filtered, input envelope, input close, output ready);
endinterface
`default_nettype wire

[src/ebed_serial_mac.sv]
`default_nettype none
// Bit-serial multiply-accumulate: adds or subtracts coef * operand into acc.
// The 32-bit operand is shifted in LSB first, one bit per cycle; the sign bit
// carries negative weight.
module ebed_serial_mac import ebed_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [31:0]      operand,
	input  wire logic signed [18:0]      coef_in,
	input  wire logic                    subtract,
	input  wire logic                    clear,
	input  wire logic signed [ACC_W-1:0] init,
	output logic                         busy,
	output logic signed [ACC_W-1:0]      acc
);
	logic [31:0]              shift_q;
	logic signed [ACC_W-1:0]  mcand_q;
	logic [5:0]               cnt_q;
	logic signed [ACC_W-1:0]  term;

	always_comb begin
		term = shift_q[0] ? mcand_q : '0;
		if (cnt_q == 6'd1) term = -term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			acc <= init;
		end else if (start) begin
			shift_q <= operand;
			mcand_q <= subtract ? -ACC_W'(coef_in) : ACC_W'(coef_in);
		end else if (cnt_q != '0) begin
			acc     <= acc + term;
			shift_q <= shift_q >> 1;
			mcand_q <= mcand_q <<< 1;
		end
	end

	assign busy = (cnt_q != '0);
endmodule
`default_nettype wire

[src/ebed_window.sv]
`default_nettype none
// Moving sum of magnitudes over the window store, one update per sample.
module ebed_window import ebed_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic             wr_en,
	input  wire logic [12:0]      mag,
	output logic [SUM_W-1:0]      sum_q
);
	logic [12:0]            mem [WINDOW_LENGTH];
	logic [WINDOW_LENGTH-1:0] vld_q;
	logic [WIN_AW-1:0]      pos_q;
	logic [12:0]            old_q;

	always_ff @(posedge clk) begin
		if (rd_en) old_q <= mem[pos_q];
		if (wr_en) mem[pos_q] <= mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			pos_q <= '0;
			sum_q <= '0;
		end else if (wr_en) begin
			sum_q <= sum_q - (vld_q[pos_q] ? SUM_W'(old_q) : '0) + SUM_W'(mag);
			vld_q[pos_q] <= 1'b1;
			pos_q <= (pos_q == WIN_AW'(WINDOW_LENGTH - 1)) ? '0 : pos_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

[src/emg_bandpass_envelope_detector_unit.sv]
`default_nettype none
// From the input transfer to the output transfer, the twenty products per sample run
// one after the other in the single bit-serial multiply-accumulate (start, 32 operand
// bits, settle); every pass adds a clear step (LOAD) and a scale step (SCALE), and the
// window update (WINDOW) and the output (OUT) follow. The unit takes one sample at a
// time; a stalled output holds the input off. Reset (arst_n low) clears the section
// delays, the window valid bits, the running sum and write position, and sets the
// thresholds to 100 and 0.
module emg_bandpass_envelope_detector_unit import ebed_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data,
	ebed_in_if.sink          in_ch,
	ebed_out_if.source       out_ch
);
	// Register indexes.
	localparam logic REG_SIGNAL = 1'b0;
	localparam logic REG_ENVELOPE = 1'b1;

	// Product indexes within a section. The feedback pass subtracts a1*z1 and a2*z2
	// from the input; the output pass sums b0*x, b1*z1 and b2*z2.
	localparam logic [2:0] TERM_A1 = 3'd1;
	localparam logic [2:0] TERM_A2 = 3'd2;
	localparam logic [2:0] TERM_B0 = 3'd3;
	localparam logic [2:0] TERM_B1 = 3'd4;
	localparam logic [2:0] TERM_B2 = 3'd5;

	ebed_state_t state_q, state_d;
	logic [11:0] sig_thr_q;
	logic [12:0] env_thr_q;
	logic signed [31:0] z_q [2*NUM_SECTIONS];
	logic signed [31:0] v_q, x_q;
	logic [1:0]  sec_q;
	logic [2:0]  term_q;
	logic        started_q;
	logic        last_term, last_sec;

	// MAC control.
	logic mac_start, mac_clear, mac_busy, mac_sub;
	logic signed [31:0] mac_op;
	logic signed [18:0] mac_coef;
	logic signed [ACC_W-1:0] mac_init, acc;
	logic signed [31:0] scaled;

	// Final result and window update.
	logic signed [12:0] filt_s1;
	logic [12:0] mag_s1;
	logic win_rd, win_wr;
	logic [SUM_W-1:0] sum_q;
	logic [ENV_W-1:0] env;

	// Floor shift by 16 and saturate to 32 bits.
	function automatic logic signed [31:0] scale_sat(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-17:0] q;
		q = a[ACC_W-1:16];
		if (q > 36'sh07FFFFFFF) return 32'sh7FFFFFFF;
		if (q < -36'sh080000000) return 32'sh80000000;
		return q[31:0];
	endfunction

	// Drops the eight fraction bits toward zero and saturates to the output range.
	function automatic logic signed [12:0] f_sat_next(input logic signed [31:0] y);
		logic [31:0] m;
		logic signed [24:0] f;
		m = y[31] ? 32'(-33'(y)) : y;
		f = y[31] ? -25'(m >> 8) : 25'(m >> 8);
		if (f > 25'sd4095) return 13'sd4095;
		if (f < -25'sd4096) return -13'sd4096;
		return f[12:0];
	endfunction

	function automatic logic [12:0] mag_of(input logic signed [12:0] f);
		return f[12] ? 13'(-14'(f)) : f;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_thr_q <= 12'd100;
			env_thr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIGNAL:   sig_thr_q <= cfg_data[11:0];
				REG_ENVELOPE: env_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Operand and coefficient for the current product. The feedback pass starts
	// from v<<16, the output pass from zero.
	always_comb begin
		mac_op = '0;
		mac_sub = 1'b0;
		case (term_q)
			TERM_A1: begin
				mac_op = z_q[{sec_q, 1'b0}];
				mac_sub = 1'b1;
			end
			TERM_A2: begin
				mac_op = z_q[{sec_q, 1'b1}];
				mac_sub = 1'b1;
			end
			TERM_B0: mac_op = x_q;
			TERM_B1: mac_op = z_q[{sec_q, 1'b0}];
			TERM_B2: mac_op = z_q[{sec_q, 1'b1}];
			default: ;
		endcase
		mac_coef = coef(sec_q, term_q - TERM_A1);
		mac_init = (term_q == TERM_A1) ? (ACC_W'(v_q) <<< 16) : '0;
	end

	assign last_term = (term_q == TERM_A2) || (term_q == TERM_B2);
	assign last_sec = (sec_q == 2'(NUM_SECTIONS - 1));
	assign scaled = scale_sat(acc);

	ebed_window u_win (.clk, .arst_n, .rd_en(win_rd), .wr_en(win_wr),
		.mag(mag_s1), .sum_q);

	ebed_serial_mac u_mac (.clk, .arst_n, .start(mac_start), .operand(mac_op),
		.coef_in(mac_coef), .subtract(mac_sub), .clear(mac_clear), .init(mac_init),
		.busy(mac_busy), .acc);

	// Each pass: LOAD clears the accumulator, MAC runs its products one after the
	// other (a start strobe, then busy until the last bit is in), SCALE takes the
	// result. After the last section the window is read in SCALE and written in WINDOW.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_ch.valid) state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_MAC;
			ST_MAC:    if (started_q && !mac_busy && last_term) state_d = ST_SCALE;
			ST_SCALE: begin
				if (term_q == TERM_B2 && last_sec) state_d = ST_WINDOW;
				else state_d = ST_LOAD;
			end
			ST_WINDOW: state_d = ST_OUT;
			ST_OUT:    if (out_ch.ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mac_clear = 1'b0;
		mac_start = 1'b0;
		win_rd = 1'b0;
		win_wr = 1'b0;
		unique case (state_q)
			ST_LOAD:   mac_clear = 1'b1;
			ST_MAC:    mac_start = !started_q;
			ST_SCALE:  win_rd = (term_q == TERM_B2) && last_sec;
			ST_WINDOW: win_wr = 1'b1;
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			started_q <= 1'b0;
			term_q <= TERM_A1;
			sec_q <= '0;
			v_q <= '0;
			x_q <= '0;
			filt_s1 <= '0;
			mag_s1 <= '0;
			for (int i = 0; i < 2*NUM_SECTIONS; i++) z_q[i] <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					v_q <= 32'(in_ch.sample) <<< 8;
					sec_q <= '0;
					term_q <= TERM_A1;
				end
				ST_LOAD: started_q <= 1'b0;
				ST_MAC: begin
					// The product finishes when busy drops; then the next one starts.
					if (!started_q) begin
						started_q <= 1'b1;
					end else if (!mac_busy && !last_term) begin
						started_q <= 1'b0;
						term_q <= term_q + 3'd1;
					end
				end
				ST_SCALE: begin
					if (term_q == TERM_A2) begin
						x_q <= scaled;
						term_q <= TERM_B0;
					end else begin
						v_q <= scaled;
						z_q[{sec_q, 1'b1}] <= z_q[{sec_q, 1'b0}];
						z_q[{sec_q, 1'b0}] <= x_q;
						term_q <= TERM_A1;
						sec_q <= sec_q + 2'd1;
						if (last_sec) begin
							filt_s1 <= f_sat_next(scaled);
							mag_s1 <= mag_of(f_sat_next(scaled));
						end
					end
				end
				default: ;
			endcase
		end
	end

	// The envelope is twice the integer mean of the window.
	assign env = ENV_W'({sum_q >> WIN_AW, 1'b0});

	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.filtered = filt_s1;
	assign out_ch.envelope = env;
	assign out_ch.close = (env > ENV_W'(env_thr_q)) ||
		(filt_s1 > $signed({1'b0, sig_thr_q}));
endmodule
`default_nettype wire
